// ----- src/upe_pkg.sv -----
package upe_pkg;

    localparam int unsigned RUN_MAX = 7;

    localparam logic [1:0] MODE_PATH     = 2'd0;
    localparam logic [1:0] MODE_QUERY    = 2'd1;
    localparam logic [1:0] MODE_FRAGMENT = 2'd2;
    localparam logic [1:0] MODE_USERINFO = 2'd3;

    localparam logic [1:0] HOLD_NONE      = 2'd0;
    localparam logic [1:0] HOLD_PCT       = 2'd1;
    localparam logic [1:0] HOLD_PCT_DIGIT = 2'd2;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    // one request's worth of output text
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    comp_last;
    } t_run;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

    function automatic logic [7:0] delim_of(input logic [1:0] mode);
        logic [7:0] d;
        case (mode)
            MODE_PATH:     d = CH_SLASH;
            MODE_QUERY:    d = CH_QUEST;
            MODE_FRAGMENT: d = CH_HASH;
            default:       d = 8'h00;
        endcase
        return d;
    endfunction

    function automatic logic passes(input logic [7:0] c, input logic [1:0] mode);
        logic unres;
        logic sub;
        logic res;
        unres = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39);
        case (c) inside
            8'h2D, 8'h2E, 8'h5F, 8'h7E: unres = 1'b1;
            default: ;
        endcase
        case (c) inside
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B,
            8'h3D:   sub = 1'b1;
            default: sub = 1'b0;
        endcase
        if (unres || sub || c == CH_COLON) begin
            res = 1'b1;
        end else if (mode == MODE_USERINFO) begin
            res = 1'b0;
        end else if (c == CH_AT) begin
            res = 1'b1;
        end else if (mode == MODE_PATH) begin
            res = 1'b0;
        end else begin
            res = (c == CH_SLASH) || (c == CH_QUEST);
        end
        return res;
    endfunction

endpackage

// ----- src/upe_in_if.sv -----
interface upe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_component;

    modport source (output valid, output data_byte, output end_of_component, input ready);
    modport sink (input valid, input data_byte, input end_of_component, output ready);
endinterface

// ----- src/upe_out_if.sv -----
interface upe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       component_last;

    modport source (output valid, output out_byte, output run_last, output component_last,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input component_last,
                  output ready);
endinterface

// ----- src/url_percent_encoder.sv -----
// Percent-encodes a URL component one byte per request in, one text byte per request out.
// i_cfg_we/i_cfg_wdata set the component mode (0 path, 1 query, 2 fragment, 3 userinfo),
// which takes effect from the next input byte. The input side takes a byte every cycle while
// the run queue of QUEUE_DEPTH entries has room; the output port drives one byte per cycle while
// o_res.ready allows, so an input byte yields one text byte when passed, three when encoded, and
// up to seven when a held escape is flushed, and a byte after '%' may produce nothing until the
// escape resolves. Sustained throughput is set by the output byte rate.
module url_percent_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upe_in_if.sink     i_req,
    upe_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    logic               r_mode;
    logic [1:0]         r_mode_q;
    logic               w_push;
    logic               w_pop;
    upe_pkg::t_run      w_run;
    upe_pkg::t_run      w_head;
    upe_pkg::t_q_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_q <= upe_pkg::MODE_PATH;
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode_q <= i_cfg_wdata;
            r_mode   <= 1'b1;
        end
    end

    upe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_mode   (r_mode_q),
        .i_status (w_status),
        .o_push   (w_push),
        .o_run    (w_run)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_run    (w_run),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    upe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    // mode holds its reset value until the first write
    a_mode_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> r_mode_q == upe_pkg::MODE_PATH)
        else $error("mode changed without a write");

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_mode && r_mode_q == $past(i_cfg_wdata))
        else $error("mode write lost");

    a_push_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> i_req.valid && i_req.ready)
        else $error("queue written without an accepted request");

endmodule

// ----- src/upe_front.sv -----
module upe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    upe_in_if.sink           i_req,
    input  logic [1:0]       i_mode,
    input  upe_pkg::t_q_status i_status,
    output logic             o_push,
    output upe_pkg::t_run    o_run
);

    logic [1:0] r_held_count, n_held_count;
    logic [7:0] r_held_digit, n_held_digit;
    logic       r_first, n_first;
    logic       w_accept;
    upe_pkg::t_run w_run;

    function automatic upe_pkg::t_run put(input upe_pkg::t_run r, input logic [7:0] b);
        upe_pkg::t_run q;
        q = r;
        if (q.count < 3'(upe_pkg::RUN_MAX)) begin
            q.bytes[q.count] = b;
            q.count          = q.count + 3'd1;
        end
        return q;
    endfunction

    function automatic upe_pkg::t_run put_enc(input upe_pkg::t_run r, input logic [7:0] b);
        upe_pkg::t_run q;
        q = put(r, upe_pkg::CH_PERCENT);
        q = put(q, upe_pkg::hex_char(b[7:4]));
        q = put(q, upe_pkg::hex_char(b[3:0]));
        return q;
    endfunction

    // failed escape: "%25" then the held digit, if one was held
    function automatic upe_pkg::t_run flush(input upe_pkg::t_run r, input logic [1:0] held,
                                            input logic [7:0] digit);
        upe_pkg::t_run q;
        q = r;
        if (held == upe_pkg::HOLD_PCT || held == upe_pkg::HOLD_PCT_DIGIT) begin
            q = put_enc(q, upe_pkg::CH_PERCENT);
        end
        if (held == upe_pkg::HOLD_PCT_DIGIT) begin
            q = put(q, digit);
        end
        return q;
    endfunction

    function automatic upe_pkg::t_run plain(input upe_pkg::t_run r, input logic [7:0] c,
                                            input logic [1:0] mode);
        upe_pkg::t_run q;
        q = r;
        if (upe_pkg::passes(c, mode)) begin
            q = put(q, c);
        end else if (c != upe_pkg::CH_PERCENT) begin
            q = put_enc(q, c);
        end
        return q;
    endfunction

    assign w_accept    = i_req.valid && !i_status.full;
    assign i_req.ready = !i_status.full;

    always_comb begin
        logic [7:0] c;
        logic       starts_hold;
        c            = i_req.data_byte;
        starts_hold  = !upe_pkg::passes(c, i_mode) && (c == upe_pkg::CH_PERCENT);
        w_run        = '0;
        n_held_count = r_held_count;
        n_held_digit = r_held_digit;
        if (r_first && i_mode != upe_pkg::MODE_USERINFO && c == upe_pkg::delim_of(i_mode)) begin
            w_run = put(w_run, c);
        end else if (r_held_count != upe_pkg::HOLD_NONE && upe_pkg::is_hex(c)) begin
            if (r_held_count == upe_pkg::HOLD_PCT) begin
                n_held_count = upe_pkg::HOLD_PCT_DIGIT;
                n_held_digit = c;
            end else begin
                w_run        = put(w_run, upe_pkg::CH_PERCENT);
                w_run        = put(w_run, r_held_digit);
                w_run        = put(w_run, c);
                n_held_count = upe_pkg::HOLD_NONE;
                n_held_digit = 8'h00;
            end
        end else begin
            w_run        = flush(w_run, r_held_count, r_held_digit);
            w_run        = plain(w_run, c, i_mode);
            n_held_count = starts_hold ? upe_pkg::HOLD_PCT : upe_pkg::HOLD_NONE;
            n_held_digit = 8'h00;
        end
        n_first = 1'b0;
        if (i_req.end_of_component) begin
            w_run        = flush(w_run, n_held_count, n_held_digit);
            n_held_count = upe_pkg::HOLD_NONE;
            n_held_digit = 8'h00;
            n_first      = 1'b1;
        end
        w_run.comp_last = i_req.end_of_component;
    end

    assign o_push = w_accept && (w_run.count != 3'd0);
    assign o_run  = w_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= upe_pkg::HOLD_NONE;
            r_held_digit <= 8'h00;
            r_first      <= 1'b1;
        end else if (w_accept) begin
            r_held_count <= n_held_count;
            r_held_digit <= n_held_digit;
            r_first      <= n_first;
        end
    end

    a_end_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.end_of_component |=> r_held_count == upe_pkg::HOLD_NONE && r_first)
        else $error("hold not cleared at component end");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.end_of_component |-> o_push)
        else $error("component end produced no output");

    a_hold_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3 && (r_held_count == upe_pkg::HOLD_PCT_DIGIT || r_held_digit == 8'h00))
        else $error("bad hold state");

endmodule

// ----- src/upe_queue.sv -----
module upe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  upe_pkg::t_run      i_run,
    input  logic               i_pop,
    output upe_pkg::t_run      o_head,
    output upe_pkg::t_q_status o_status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    upe_pkg::t_run r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_status.empty = (r_cnt == CW'(0));
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- src/upe_back.sv -----
module upe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upe_pkg::t_run      i_head,
    input  upe_pkg::t_q_status i_status,
    output logic               o_pop,
    upe_out_if.source          o_res
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_comp_last;
    logic       w_can_load;
    logic       w_load;
    logic       w_end;

    assign w_can_load = !r_valid || o_res.ready;
    assign w_load     = w_can_load && !i_status.empty;
    assign w_end      = (r_idx == i_head.count - 3'd1);
    assign o_pop      = w_load && w_end;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte      <= i_head.bytes[r_idx];
            r_run_last  <= w_end;
            r_comp_last <= w_end && i_head.comp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (w_can_load) begin
                r_valid <= w_load;
            end
            if (w_load) begin
                r_idx <= w_end ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.out_byte       = r_byte;
    assign o_res.run_last       = r_run_last;
    assign o_res.component_last = r_comp_last;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_status.empty |-> r_idx < i_head.count)
        else $error("byte index past end of run");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.empty |-> r_idx == 3'd0)
        else $error("byte index not reset between runs");

    a_comp_implies_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_comp_last |-> r_run_last)
        else $error("component end not on run end");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SETTLE_TICKS = 20;

    typedef struct {
        logic [7:0] text;
        logic       run_end;
        logic       comp_end;
    } t_text_byte;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    upe_in_if  req_if ();
    upe_out_if res_if ();

    url_percent_encoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // encoder state as seen by the scoreboard
    logic [1:0]  enc_mode;
    logic [1:0]  hold_state;
    logic [7:0]  hold_digit;
    logic        first_byte;
    logic [7:0]  run_text[$];
    t_text_byte  pending_text[$];

    int unsigned mismatches;
    int unsigned cycle_count;
    bit          no_stall;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit kept_literal(input logic [7:0] c, input logic [1:0] m);
        bit alnum;
        bit mark;
        alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
        mark = 1'b0;
        case (c)
            "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=",
            upe_pkg::CH_COLON: mark = 1'b1;
            default: mark = 1'b0;
        endcase
        if (alnum || mark) begin
            return 1'b1;
        end
        if (m == upe_pkg::MODE_USERINFO) begin
            return 1'b0;
        end
        if (c == upe_pkg::CH_AT) begin
            return 1'b1;
        end
        if (m == upe_pkg::MODE_PATH) begin
            return 1'b0;
        end
        return (c == upe_pkg::CH_SLASH) || (c == upe_pkg::CH_QUEST);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? ("0" + 8'(n)) : ("A" + 8'(n) - 8'd10);
    endfunction

    task automatic put_text(input logic [7:0] c);
        if (run_text.size() < upe_pkg::RUN_MAX) begin
            run_text.push_back(c);
        end
    endtask

    task automatic put_escaped(input logic [7:0] c);
        put_text(upe_pkg::CH_PERCENT);
        put_text(nibble_char(c[7:4]));
        put_text(nibble_char(c[3:0]));
    endtask

    // a broken escape goes out as %25 plus the digit, if one was held
    task automatic release_hold();
        if (hold_state != upe_pkg::HOLD_NONE) begin
            put_escaped(upe_pkg::CH_PERCENT);
        end
        if (hold_state == upe_pkg::HOLD_PCT_DIGIT) begin
            put_text(hold_digit);
        end
        hold_state = upe_pkg::HOLD_NONE;
        hold_digit = 8'h00;
    endtask

    task automatic encode_plain(input logic [7:0] c);
        if (kept_literal(c, enc_mode)) begin
            put_text(c);
        end else if (c == upe_pkg::CH_PERCENT) begin
            hold_state = upe_pkg::HOLD_PCT;
        end else begin
            put_escaped(c);
        end
    endtask

    task automatic encode_byte(input logic [7:0] c, input logic last);
        logic [7:0] delim;
        t_text_byte tb_item;
        run_text.delete();
        case (enc_mode)
            upe_pkg::MODE_PATH:     delim = upe_pkg::CH_SLASH;
            upe_pkg::MODE_QUERY:    delim = upe_pkg::CH_QUEST;
            upe_pkg::MODE_FRAGMENT: delim = upe_pkg::CH_HASH;
            default:                delim = 8'h00;
        endcase
        if (first_byte && enc_mode != upe_pkg::MODE_USERINFO && c == delim) begin
            put_text(c);
        end else if (hold_state == upe_pkg::HOLD_PCT) begin
            if (is_hex_char(c)) begin
                hold_digit = c;
                hold_state = upe_pkg::HOLD_PCT_DIGIT;
            end else begin
                release_hold();
                encode_plain(c);
            end
        end else if (hold_state == upe_pkg::HOLD_PCT_DIGIT) begin
            if (is_hex_char(c)) begin
                put_text(upe_pkg::CH_PERCENT);
                put_text(hold_digit);
                put_text(c);
                hold_state = upe_pkg::HOLD_NONE;
                hold_digit = 8'h00;
            end else begin
                release_hold();
                encode_plain(c);
            end
        end else begin
            encode_plain(c);
        end
        first_byte = 1'b0;
        if (last) begin
            release_hold();
            first_byte = 1'b1;
        end
        foreach (run_text[i]) begin
            tb_item.text     = run_text[i];
            tb_item.run_end  = (i == run_text.size() - 1);
            tb_item.comp_end = (i == run_text.size() - 1) && last;
            pending_text.push_back(tb_item);
        end
    endtask

    always @(posedge clk) begin
        t_text_byte want;
        if (!rst_n) begin
            enc_mode   = upe_pkg::MODE_PATH;
            hold_state = upe_pkg::HOLD_NONE;
            hold_digit = 8'h00;
            first_byte = 1'b1;
            pending_text.delete();
        end else begin
            if (cfg_we) begin
                enc_mode = cfg_wdata;
            end
            if (req_if.valid && req_if.ready) begin
                encode_byte(req_if.data_byte, req_if.end_of_component);
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_text.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output expected none actual %h/%b/%b", $time,
                             res_if.out_byte, res_if.run_last, res_if.component_last);
                end else begin
                    want = pending_text.pop_front();
                    if (res_if.out_byte !== want.text || res_if.run_last !== want.run_end ||
                        res_if.component_last !== want.comp_end) begin
                        mismatches++;
                        $display("%0t: byte/run/comp expected %h/%b/%b actual %h/%b/%b",
                                 $time, want.text, want.run_end, want.comp_end,
                                 res_if.out_byte, res_if.run_last, res_if.component_last);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[url_percent_encoder] ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_if.ready <= no_stall || ($urandom_range(99) >= 32);
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = 0;
        if (!no_stall) begin
            while (gap < 8 && $urandom_range(99) < 32) begin
                gap++;
            end
        end
        @(negedge clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid            <= 1'b1;
        req_if.data_byte        <= c;
        req_if.end_of_component <= last;
        forever begin
            @(posedge clk);
            if (req_if.ready) begin
                break;
            end
        end
    endtask

    // stop sending and wait for every pending request's text to come out
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_text.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(21);
        if (v < 10) begin
            return "0" + 8'(v);
        end else if (v < 16) begin
            return "a" + 8'(v - 10);
        end
        return "A" + 8'(v - 16);
    endfunction

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    // path mode from reset: leading delimiter, extremes, good and bad escapes
    task automatic test_path_text();
        send_byte(upe_pkg::CH_SLASH, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("Z", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("%4f%7x@", 1'b0);
        send_byte(upe_pkg::CH_PERCENT, 1'b1);
        settle();
    endtask

    task automatic test_component_modes();
        set_mode(upe_pkg::MODE_QUERY);
        send_text("?/#", 1'b1);
        settle();
        set_mode(upe_pkg::MODE_FRAGMENT);
        send_text("#?%A", 1'b1);
        settle();
        set_mode(upe_pkg::MODE_USERINFO);
        send_text("@:%", 1'b1);
        settle();
    endtask

    // escape opened in userinfo mode, finished after a switch to path mode
    task automatic test_mode_switch_inside();
        send_byte(upe_pkg::CH_PERCENT, 1'b0);
        settle();
        set_mode(upe_pkg::MODE_PATH);
        send_text("41@", 1'b1);
        settle();
    endtask

    task automatic send_random_text(input logic [1:0] m, input int unsigned count);
        logic [7:0]  c;
        logic        last;
        bit          start;
        int unsigned esc_left;
        start    = 1'b1;
        esc_left = 0;
        for (int unsigned i = 0; i < count; i++) begin
            if (esc_left > 0 && $urandom_range(99) < 85) begin
                c = rand_hex_char();
            end else if (start && $urandom_range(99) < 40) begin
                case (m)
                    upe_pkg::MODE_PATH:     c = upe_pkg::CH_SLASH;
                    upe_pkg::MODE_QUERY:    c = upe_pkg::CH_QUEST;
                    upe_pkg::MODE_FRAGMENT: c = upe_pkg::CH_HASH;
                    default:                c = upe_pkg::CH_AT;
                endcase
            end else begin
                case ($urandom_range(9))
                    0, 1: c = 8'($urandom_range(255));
                    2: c = upe_pkg::CH_PERCENT;
                    3: begin
                        case ($urandom_range(4))
                            0: c = upe_pkg::CH_SLASH;
                            1: c = upe_pkg::CH_QUEST;
                            2: c = upe_pkg::CH_HASH;
                            3: c = upe_pkg::CH_AT;
                            default: c = upe_pkg::CH_COLON;
                        endcase
                    end
                    default: c = 8'($urandom_range(8'h7E, 8'h20));
                endcase
            end
            esc_left = (c == upe_pkg::CH_PERCENT) ? 2 : ((esc_left > 0) ? esc_left - 1 : 0);
            last  = ($urandom_range(99) < 12);
            send_byte(c, last);
            start = last;
        end
    endtask

    // each phase may leave a component open, so the next mode lands mid-component
    task automatic test_random_text();
        logic [1:0] modes[6];
        modes = '{upe_pkg::MODE_USERINFO, upe_pkg::MODE_PATH, 2'($urandom_range(3)),
                  upe_pkg::MODE_QUERY, upe_pkg::MODE_FRAGMENT, 2'($urandom_range(3))};
        for (int p = 0; p < 6; p++) begin
            set_mode(modes[p]);
            no_stall = (p == 3);
            send_random_text(modes[p], 60);
            settle();
        end
        no_stall = 1'b0;
    endtask

    initial begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = upe_pkg::MODE_PATH;
        req_if.valid            = 1'b0;
        req_if.data_byte        = 8'h00;
        req_if.end_of_component = 1'b0;
        res_if.ready            = 1'b0;
        no_stall                = 1'b0;
        mismatches              = 0;
        cycle_count             = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_path_text();
        test_component_modes();
        test_mode_switch_inside();
        test_random_text();
        settle();

        if (mismatches == 0 && pending_text.size() == 0) begin
            $display("[url_percent_encoder] OK");
        end else begin
            $display("[url_percent_encoder] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/upe_pkg.sv
src/upe_in_if.sv
src/upe_out_if.sv
src/upe_front.sv
src/upe_queue.sv
src/upe_back.sv
src/url_percent_encoder.sv
tb/tb_top.sv
